// ----- design/mbpfp_pkg.sv -----
// Shared field kinds, function codes and limits for the Modbus PDU field parser.
package mbpfp_pkg;

    typedef enum logic [3:0] {
        KIND_SLAVE      = 4'd0,
        KIND_FUNC       = 4'd1,
        KIND_EXCEPTION  = 4'd2,
        KIND_ADDRESS    = 4'd3,
        KIND_QUANTITY   = 4'd4,
        KIND_BYTE_COUNT = 4'd5,
        KIND_SINGLE_REG = 4'd6,
        KIND_SINGLE_COIL = 4'd7,
        KIND_REG_VALUE  = 4'd8,
        KIND_BIT        = 4'd9
    } field_kind_t;

    localparam logic [7:0] FC_READ_COILS      = 8'd1;
    localparam logic [7:0] FC_READ_DISCRETE   = 8'd2;
    localparam logic [7:0] FC_READ_INPUT_REGS = 8'd4;
    localparam logic [7:0] FC_WRITE_COIL      = 8'd5;
    localparam logic [7:0] FC_WRITE_REG       = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS     = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS      = 8'd16;
    localparam logic [7:0] FC_EXCEPTION_BASE  = 8'h80;

    localparam logic [15:0] COIL_ON_WORD  = 16'hFF00;
    localparam logic [15:0] COIL_OFF_WORD = 16'h0000;
    localparam logic [15:0] COIL_ON       = 16'd1;
    localparam logic [15:0] COIL_OFF      = 16'd0;
    localparam logic [15:0] COIL_INVALID  = 16'd2;

    localparam logic [8:0] POS_MAX = 9'd511;

endpackage

// ----- design/modbus_pdu_field_parser.sv -----
// Modbus PDU field parser: turns a stream of frame bytes into typed field requests.
// The first result of a byte appears in the cycle after the byte is accepted.
// A coil or discrete-input data byte gives eight bit results.
// Every other byte gives at most one result; bytes go in one per cycle unless stalled.
// A new byte is accepted while the last result of the previous one is being taken.
// Synchronous active-low reset clears the frame state and drops any pending result.
module modbus_pdu_field_parser
    import mbpfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // data_byte [7:0]
    input  logic        s_tuser,  // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // field_value [15:0], item_index [26:16], zero [31:27]
    output logic [3:0]  m_tuser,  // field_kind [3:0]
    output logic        m_tlast   // last_of_run
);

    logic [8:0]  pos_reg, pos_next, pos;
    logic [7:0]  fc_reg, fc_next;
    logic [7:0]  held_reg, held_next;
    logic [7:0]  left_reg, left_next;
    logic [10:0] vc_reg, vc_next;

    logic        run_valid_reg;
    logic        run_bits_reg;
    field_kind_t run_kind_reg;
    logic [15:0] run_value_reg;
    logic [10:0] run_index_reg;
    logic [2:0]  run_sub_reg;

    logic        emit_one, emit_bits, data_phase;
    field_kind_t e_kind;
    logic [15:0] e_value, word;
    logic [10:0] e_index;
    logic        accept, out_take;

    always_comb begin
        pos        = s_tuser ? 9'd0 : pos_reg;
        fc_next    = fc_reg;
        held_next  = held_reg;
        left_next  = left_reg;
        vc_next    = vc_reg;
        emit_one   = 1'b0;
        emit_bits  = 1'b0;
        data_phase = 1'b0;
        e_kind     = KIND_SLAVE;
        e_value    = {8'd0, s_tdata};
        e_index    = 11'd0;
        word       = {held_reg, s_tdata};

        if (pos == 9'd0) begin
            fc_next   = 8'd0;
            held_next = 8'd0;
            left_next = 8'd0;
            vc_next   = 11'd0;
            emit_one  = 1'b1;
            e_kind    = KIND_SLAVE;
        end else if (pos == 9'd1) begin
            fc_next  = s_tdata;
            emit_one = 1'b1;
            e_kind   = KIND_FUNC;
        end else if (fc_reg > FC_EXCEPTION_BASE) begin
            if (pos == 9'd2) begin
                emit_one = 1'b1;
                e_kind   = KIND_EXCEPTION;
            end
        end else if (fc_reg inside {[FC_READ_COILS:FC_READ_INPUT_REGS]}) begin
            if (pos == 9'd2) begin
                left_next = s_tdata;
                vc_next   = 11'd0;
                emit_one  = 1'b1;
                e_kind    = KIND_BYTE_COUNT;
            end else begin
                data_phase = 1'b1;
            end
        end else begin
            if (pos == 9'd2 || pos == 9'd4) begin
                held_next = s_tdata;
            end else if (pos == 9'd3) begin
                emit_one = 1'b1;
                e_kind   = KIND_ADDRESS;
                e_value  = word;
            end else if (pos == 9'd5) begin
                emit_one = 1'b1;
                if (fc_reg == FC_WRITE_COIL) begin
                    e_kind = KIND_SINGLE_COIL;
                    if (word == COIL_ON_WORD) begin
                        e_value = COIL_ON;
                    end else if (word == COIL_OFF_WORD) begin
                        e_value = COIL_OFF;
                    end else begin
                        e_value = COIL_INVALID;
                    end
                end else if (fc_reg == FC_WRITE_REG) begin
                    e_kind  = KIND_SINGLE_REG;
                    e_value = word;
                end else begin
                    e_kind  = KIND_QUANTITY;
                    e_value = word;
                end
            end else if (fc_reg == FC_WRITE_COILS || fc_reg == FC_WRITE_REGS) begin
                if (pos == 9'd6) begin
                    left_next = s_tdata;
                    vc_next   = 11'd0;
                    emit_one  = 1'b1;
                    e_kind    = KIND_BYTE_COUNT;
                end else begin
                    data_phase = 1'b1;
                end
            end
        end

        if (data_phase && left_reg != 8'd0) begin
            left_next = left_reg - 8'd1;
            if (fc_reg == FC_READ_COILS || fc_reg == FC_READ_DISCRETE ||
                fc_reg == FC_WRITE_COILS) begin
                emit_bits = 1'b1;
                e_kind    = KIND_BIT;
                e_index   = vc_reg;
                vc_next   = vc_reg + 11'd8;
            end else if (pos[0]) begin
                held_next = s_tdata;
            end else begin
                emit_one = 1'b1;
                e_kind   = KIND_REG_VALUE;
                e_value  = word;
                e_index  = vc_reg;
                vc_next  = vc_reg + 11'd1;
            end
        end

        pos_next = (pos < POS_MAX) ? pos + 9'd1 : POS_MAX;
    end

    assign m_tvalid = run_valid_reg;
    assign m_tuser  = run_kind_reg;
    assign m_tlast  = !run_bits_reg || run_sub_reg == 3'd7;
    assign m_tdata  = {5'd0, run_index_reg + {8'd0, run_sub_reg},
                       run_bits_reg ? {15'd0, run_value_reg[run_sub_reg]} : run_value_reg};

    assign out_take = m_tvalid && m_tready;
    assign s_tready = !run_valid_reg || (m_tready && m_tlast);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= 9'd0;
            fc_reg        <= 8'd0;
            held_reg      <= 8'd0;
            left_reg      <= 8'd0;
            vc_reg        <= 11'd0;
            run_valid_reg <= 1'b0;
            run_bits_reg  <= 1'b0;
            run_sub_reg   <= 3'd0;
        end else begin
            if (accept && (emit_one || emit_bits)) begin
                run_valid_reg <= 1'b1;
                run_bits_reg  <= emit_bits;
                run_sub_reg   <= 3'd0;
            end else if (out_take) begin
                if (m_tlast) begin
                    run_valid_reg <= 1'b0;
                end else begin
                    run_sub_reg <= run_sub_reg + 3'd1;
                end
            end
            if (accept) begin
                pos_reg  <= pos_next;
                fc_reg   <= fc_next;
                held_reg <= held_next;
                left_reg <= left_next;
                vc_reg   <= vc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (emit_one || emit_bits)) begin
            run_kind_reg  <= e_kind;
            run_value_reg <= e_value;
            run_index_reg <= e_index;
        end
    end

    a_sub_only_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        run_valid_reg && !run_bits_reg |-> run_sub_reg == 3'd0)
        else $error("sub-counter moved outside a bit run");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !run_valid_reg |-> s_tready)
        else $error("input stalled with no pending result");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && run_bits_reg)
        else $error("bit run ended early");

    a_pos_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> pos_reg != 9'd0)
        else $error("byte position did not advance");

endmodule
